[sv/bde_pkg.sv]
// Shared types, codes and helpers for the bounded deque engine.
`default_nettype none
package bde_pkg;

   localparam int MAX_ELEMENTS_DEF = 4096;
   localparam int SLOT_W = 16;
   localparam int LEN_W = 17;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 13;

   localparam logic [3:0] REQ_RESIZE = 4'd0;
   localparam logic [3:0] REQ_DELETE = 4'd1;
   localparam logic [3:0] REQ_SIZE = 4'd2;
   localparam logic [3:0] REQ_READ = 4'd3;
   localparam logic [3:0] REQ_WRITE = 4'd4;
   localparam logic [3:0] REQ_PUSH_FRONT = 4'd5;
   localparam logic [3:0] REQ_PUSH_BACK = 4'd6;
   localparam logic [3:0] REQ_POP_FRONT = 4'd7;
   localparam logic [3:0] REQ_POP_BACK = 4'd8;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_BAD_INDEX = 4'd1;
   localparam logic [3:0] ST_NEGATIVE = 4'd2;
   localparam logic [3:0] ST_RANGE = 4'd3;
   localparam logic [3:0] ST_RESIZE_QUEUE = 4'd4;
   localparam logic [3:0] ST_SIZE_LIMIT = 4'd5;
   localparam logic [3:0] ST_MISMATCH = 4'd6;
   localparam logic [3:0] ST_NOT_QUEUE = 4'd7;
   localparam logic [3:0] ST_EMPTY = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_IS_QUEUE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_BOUND = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_WIDTH = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_UNKNOWN = 4'd3;

   typedef enum logic [1:0] {
      OP_RESP,
      OP_WRITE,
      OP_READ,
      OP_FILL
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
      logic [63:0]       value;
      logic [63:0]       unknown;
      logic [3:0]        status;
   } cmd_type;

   function automatic logic [63:0] width_mask(input logic [6:0] w);
      logic [63:0] m;
      if (w >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << w) - 64'd1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

[sv/bde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bde_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 4096
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  wire logic [WIDTH-1:0]                              wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic      [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[sv/bde_fifo.sv]
// Two-entry command queue between the front and back ends.
`default_nettype none
module bde_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bde_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output bde_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);
   bde_pkg::cmd_type entry_ff [2];
   logic             rd_ff;
   logic             wr_ff;
   logic [1:0]       cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            entry_ff[wr_ff] <= push_cmd;
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head_cmd = entry_ff[rd_ff];
   assign empty = (cnt_ff == 2'd0);
   assign full = (cnt_ff == 2'd2);
endmodule
`default_nettype wire

[sv/bde_front.sv]
// Front end: configuration, request checks, head and count bookkeeping.
`default_nettype none
module bde_front #(
   parameter int MAX_ELEMENTS = bde_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bde_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            accept,
   input  wire logic [3:0]                      req_type,
   input  wire logic [63:0]                     req_index_value,
   input  wire logic                            req_index_unknown,
   input  wire logic [6:0]                      req_index_width,
   input  wire logic                            req_index_signed,
   input  wire logic [63:0]                     req_data_value,
   input  wire logic [63:0]                     req_data_unknown_bits,
   input  wire logic [6:0]                      req_data_width,
   output bde_pkg::cmd_type                     cmd
);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   logic          is_queue_ff;
   logic [12:0]   queue_bound_ff;
   logic [6:0]    element_width_ff;
   logic          no_unknown_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;

   logic [63:0]   dmask;
   logic [63:0]   dv;
   logic [63:0]   du;
   logic          idx_bad;
   logic          sgn_use;
   logic [63:0]   idx_rw;
   logic          type_ok;
   logic [CW-1:0] bound;
   logic [CW:0]   cnt_p1;
   logic [CW-1:0] push_cnt;
   logic [AW-1:0] head_dec;

   function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
      logic [AW:0] r;
      r = sum;
      if (sum >= (AW+1)'(MAX_ELEMENTS)) begin
         r = sum - (AW+1)'(MAX_ELEMENTS);
      end
      return r[AW-1:0];
   endfunction

   always_comb begin
      dmask = bde_pkg::width_mask(req_data_width);
      dv = req_data_value & dmask;
      du = req_data_unknown_bits & dmask;
      idx_bad = (req_index_width == 7'd0) || (req_index_width > 7'd64) || req_index_unknown;
      sgn_use = req_index_signed && (req_index_width <= 7'd32);
      idx_rw = sgn_use ? {32'd0, req_index_value[31:0]} : req_index_value;
      type_ok = (req_data_width == element_width_ff) && !(no_unknown_ff && (du != 64'd0));
      if ((queue_bound_ff == 13'd0) || ({19'd0, queue_bound_ff} > 32'(MAX_ELEMENTS))) begin
         bound = CW'(MAX_ELEMENTS);
      end else begin
         bound = CW'(queue_bound_ff);
      end
      cnt_p1 = {1'b0, cnt_ff} + (CW+1)'(1);
      push_cnt = (cnt_p1 > {1'b0, bound}) ? cnt_ff : cnt_p1[CW-1:0];
      head_dec = (head_ff == '0) ? AW'(MAX_ELEMENTS - 1) : head_ff - AW'(1);

      cmd.op = bde_pkg::OP_RESP;
      cmd.slot = '0;
      cmd.len = '0;
      cmd.value = 64'd0;
      cmd.unknown = 64'd0;
      cmd.status = bde_pkg::ST_OK;
      cnt_in = cnt_ff;
      head_in = head_ff;

      case (req_type)
         bde_pkg::REQ_RESIZE: begin
            if (is_queue_ff) begin
               cmd.status = bde_pkg::ST_RESIZE_QUEUE;
            end else if (idx_bad) begin
               cmd.status = bde_pkg::ST_BAD_INDEX;
            end else if (req_index_value > 64'(MAX_ELEMENTS)) begin
               cmd.status = bde_pkg::ST_SIZE_LIMIT;
            end else begin
               cmd.op = bde_pkg::OP_FILL;
               cmd.len = bde_pkg::LEN_W'(req_index_value[CW-1:0]);
               cnt_in = req_index_value[CW-1:0];
               head_in = '0;
            end
         end
         bde_pkg::REQ_DELETE: begin
            cnt_in = '0;
            head_in = '0;
         end
         bde_pkg::REQ_SIZE: begin
            cmd.value = 64'(cnt_ff);
         end
         bde_pkg::REQ_READ, bde_pkg::REQ_WRITE: begin
            if (idx_bad) begin
               cmd.status = bde_pkg::ST_BAD_INDEX;
            end else if (sgn_use && req_index_value[31]) begin
               cmd.status = bde_pkg::ST_NEGATIVE;
            end else if (idx_rw >= 64'(cnt_ff)) begin
               cmd.status = bde_pkg::ST_RANGE;
            end else if (req_type == bde_pkg::REQ_READ) begin
               cmd.op = bde_pkg::OP_READ;
               cmd.slot = bde_pkg::SLOT_W'(wrap({1'b0, head_ff} + (AW+1)'(idx_rw[AW-1:0])));
            end else if (!type_ok) begin
               cmd.status = bde_pkg::ST_MISMATCH;
            end else begin
               cmd.op = bde_pkg::OP_WRITE;
               cmd.slot = bde_pkg::SLOT_W'(wrap({1'b0, head_ff} + (AW+1)'(idx_rw[AW-1:0])));
               cmd.value = dv;
               cmd.unknown = du;
            end
         end
         bde_pkg::REQ_PUSH_FRONT, bde_pkg::REQ_PUSH_BACK: begin
            if (!is_queue_ff) begin
               cmd.status = bde_pkg::ST_NOT_QUEUE;
            end else if (!type_ok) begin
               cmd.status = bde_pkg::ST_MISMATCH;
            end else if (req_type == bde_pkg::REQ_PUSH_FRONT) begin
               cmd.op = bde_pkg::OP_WRITE;
               cmd.slot = bde_pkg::SLOT_W'(head_dec);
               cmd.value = dv;
               cmd.unknown = du;
               head_in = head_dec;
               cnt_in = push_cnt;
            end else if (cnt_ff < CW'(MAX_ELEMENTS)) begin
               cmd.op = bde_pkg::OP_WRITE;
               cmd.slot = bde_pkg::SLOT_W'(wrap({1'b0, head_ff} + (AW+1)'(cnt_ff)));
               cmd.value = dv;
               cmd.unknown = du;
               cnt_in = push_cnt;
            end
         end
         bde_pkg::REQ_POP_FRONT, bde_pkg::REQ_POP_BACK: begin
            if (!is_queue_ff) begin
               cmd.status = bde_pkg::ST_NOT_QUEUE;
            end else if (cnt_ff == '0) begin
               cmd.status = bde_pkg::ST_EMPTY;
            end else begin
               cmd.op = bde_pkg::OP_READ;
               cnt_in = cnt_ff - CW'(1);
               if (req_type == bde_pkg::REQ_POP_FRONT) begin
                  cmd.slot = bde_pkg::SLOT_W'(head_ff);
                  head_in = wrap({1'b0, head_ff} + (AW+1)'(1));
               end else begin
                  cmd.slot = bde_pkg::SLOT_W'(wrap({1'b0, head_ff}
                                                   + (AW+1)'(cnt_ff - CW'(1))));
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_queue_ff <= 1'b1;
         queue_bound_ff <= 13'd0;
         element_width_ff <= 7'd32;
         no_unknown_ff <= 1'b0;
         cnt_ff <= '0;
         head_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bde_pkg::CSR_IS_QUEUE: is_queue_ff <= csr_wdata[0];
               bde_pkg::CSR_QUEUE_BOUND: queue_bound_ff <= csr_wdata;
               bde_pkg::CSR_ELEMENT_WIDTH: element_width_ff <= csr_wdata[6:0];
               bde_pkg::CSR_NO_UNKNOWN: no_unknown_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            cnt_ff <= cnt_in;
            head_ff <= head_in;
         end
      end
   end
endmodule
`default_nettype wire

[sv/bde_back.sv]
// Back end: element store access, zero-fill walk and result register.
`default_nettype none
module bde_back #(
   parameter int MAX_ELEMENTS = bde_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bde_pkg::cmd_type head_cmd,
   input  wire logic             empty,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_result_value,
   output logic [63:0]           rsp_result_unknown_bits,
   output logic [3:0]            rsp_status
);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_FILL
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] len_ff;
   logic          valid_ff;
   logic [63:0]   value_ff;
   logic [63:0]   unknown_ff;
   logic [3:0]    status_ff;

   logic          we;
   logic [AW-1:0] waddr;
   logic [127:0]  wdata;
   logic [AW-1:0] raddr;
   logic [127:0]  rdata;

   bde_ram #(
      .WIDTH(128),
      .DEPTH(MAX_ELEMENTS)
   ) u_ram (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_comb begin
      we = 1'b0;
      pop = 1'b0;
      waddr = head_cmd.slot[AW-1:0];
      wdata = {head_cmd.unknown, head_cmd.value};
      raddr = head_cmd.slot[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               we = (head_cmd.op == bde_pkg::OP_WRITE);
            end
         end
         S_FILL: begin
            we = 1'b1;
            waddr = fill_ff[AW-1:0];
            wdata = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!empty) begin
                  case (head_cmd.op)
                     bde_pkg::OP_READ: begin
                        state_ff <= S_READ;
                     end
                     bde_pkg::OP_FILL: begin
                        if (head_cmd.len == '0) begin
                           valid_ff <= 1'b1;
                           value_ff <= 64'd0;
                           unknown_ff <= 64'd0;
                           status_ff <= bde_pkg::ST_OK;
                        end else begin
                           fill_ff <= '0;
                           len_ff <= head_cmd.len[CW-1:0];
                           state_ff <= S_FILL;
                        end
                     end
                     default: begin
                        valid_ff <= 1'b1;
                        value_ff <= (head_cmd.op == bde_pkg::OP_WRITE) ? 64'd0
                                                                       : head_cmd.value;
                        unknown_ff <= 64'd0;
                        status_ff <= head_cmd.status;
                     end
                  endcase
               end
            end
            S_READ: begin
               valid_ff <= 1'b1;
               value_ff <= rdata[63:0];
               unknown_ff <= rdata[127:64];
               status_ff <= bde_pkg::ST_OK;
               state_ff <= S_IDLE;
            end
            S_FILL: begin
               fill_ff <= fill_ff + CW'(1);
               if (fill_ff == len_ff - CW'(1)) begin
                  valid_ff <= 1'b1;
                  value_ff <= 64'd0;
                  unknown_ff <= 64'd0;
                  status_ff <= bde_pkg::ST_OK;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_value = value_ff;
   assign rsp_result_unknown_bits = unknown_ff;
   assign rsp_status = status_ff;
endmodule
`default_nettype wire

[sv/bounded_deque_engine_top.sv]
// Bounded deque engine: four-state element store acting as dynamic array or bounded queue.
// Results pass the command queue and result register; read and pop also the registered RAM read port.
// Throughput: one request per cycle while busy is low; read and pop also pass the S_READ state.
// Resize to size N: zero-fill walk over slots 0 to N-1, then the result transfer.
// A two-entry command queue holds accepted transfers; busy is high while it is full.
// Synchronous active-high reset clears count and head and restores the configuration defaults; store contents persist.
`default_nettype none
module bounded_deque_engine_top #(
   parameter int MAX_ELEMENTS = bde_pkg::MAX_ELEMENTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bde_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [3:0]                      req_type,
   input  wire logic [63:0]                     req_index_value,
   input  wire logic                            req_index_unknown,
   input  wire logic [6:0]                      req_index_width,
   input  wire logic                            req_index_signed,
   input  wire logic [63:0]                     req_data_value,
   input  wire logic [63:0]                     req_data_unknown_bits,
   input  wire logic [6:0]                      req_data_width,
   output logic                                 rsp_valid,
   output logic [63:0]                          rsp_result_value,
   output logic [63:0]                          rsp_result_unknown_bits,
   output logic [3:0]                           rsp_status
);
   logic             accept;
   logic             full;
   logic             empty;
   logic             pop;
   bde_pkg::cmd_type new_cmd;
   bde_pkg::cmd_type head_cmd;

   assign busy = full;
   assign accept = start && !full;

   bde_front #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .req_type(req_type),
      .req_index_value(req_index_value),
      .req_index_unknown(req_index_unknown),
      .req_index_width(req_index_width),
      .req_index_signed(req_index_signed),
      .req_data_value(req_data_value),
      .req_data_unknown_bits(req_data_unknown_bits),
      .req_data_width(req_data_width),
      .cmd(new_cmd)
   );

   bde_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(accept),
      .push_cmd(new_cmd),
      .pop(pop),
      .head_cmd(head_cmd),
      .empty(empty),
      .full(full)
   );

   bde_back #(
      .MAX_ELEMENTS(MAX_ELEMENTS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head_cmd(head_cmd),
      .empty(empty),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value),
      .rsp_result_unknown_bits(rsp_result_unknown_bits),
      .rsp_status(rsp_status)
   );
endmodule
`default_nettype wire

[tb/sv/tb_bounded_deque_engine_top.sv]
// Self-checking testbench for the bounded deque engine: directed and random requests.
`default_nettype none

typedef struct {
   logic [3:0]  kind;
   logic [63:0] idx_v;
   logic        idx_u;
   logic [6:0]  idx_w;
   logic        idx_s;
   logic [63:0] dv;
   logic [63:0] du;
   logic [6:0]  dw;
} deque_req_type;

typedef struct {
   logic [63:0] value;
   logic [63:0] unknown;
   logic [3:0]  status;
} deque_rsp_type;

class deque_scoreboard;
   logic [63:0]   vals [4096];
   logic [63:0]   unks [4096];
   int            head;
   int            count;
   bit            is_queue;
   int            bound;
   int            elem_w;
   bit            no_unknown;
   deque_rsp_type awaited [$];
   int            errors;

   function new();
      head = 0;
      count = 0;
      is_queue = 1;
      bound = 0;
      elem_w = 32;
      no_unknown = 0;
      errors = 0;
   endfunction

   function logic [63:0] mask_of(logic [6:0] w);
      logic [63:0] m;
      m = (w >= 7'd64) ? '1 : ~({64{1'b1}} << w);
      return m;
   endfunction

   function int slot(int pos);
      return (head + pos) % 4096;
   endfunction

   function logic [3:0] idx_check(deque_req_type r, bit allow_signed,
                                  output logic [63:0] idx);
      idx = r.idx_v;
      if (r.idx_w == 0 || r.idx_w > 64 || r.idx_u) return bde_pkg::ST_BAD_INDEX;
      if (allow_signed && r.idx_s && r.idx_w <= 32) begin
         if (r.idx_v[31]) return bde_pkg::ST_NEGATIVE;
         idx = {32'd0, r.idx_v[31:0]};
      end
      return bde_pkg::ST_OK;
   endfunction

   function bit type_ok(deque_req_type r);
      if (int'(r.dw) != elem_w) return 0;
      if (no_unknown && (r.du & mask_of(r.dw)) != 0) return 0;
      return 1;
   endfunction

   function void set_reg(logic [3:0] idx, logic [12:0] data);
      case (idx)
         bde_pkg::CSR_IS_QUEUE: is_queue = data[0];
         bde_pkg::CSR_QUEUE_BOUND: bound = int'(data);
         bde_pkg::CSR_ELEMENT_WIDTH: elem_w = int'(data[6:0]);
         bde_pkg::CSR_NO_UNKNOWN: no_unknown = data[0];
         default: ;
      endcase
   endfunction

   // accepted request: update the model and queue its expected response
   function void note(deque_req_type r);
      deque_rsp_type e;
      logic [63:0]   idx;
      logic [63:0]   dv;
      logic [63:0]   du;
      int            s;
      int            lim;
      e.value = 0;
      e.unknown = 0;
      e.status = bde_pkg::ST_OK;
      dv = r.dv & mask_of(r.dw);
      du = r.du & mask_of(r.dw);
      lim = (bound == 0 || bound > 4096) ? 4096 : bound;
      case (r.kind)
         bde_pkg::REQ_RESIZE: begin
            if (is_queue) e.status = bde_pkg::ST_RESIZE_QUEUE;
            else begin
               e.status = idx_check(r, 0, idx);
               if (e.status == bde_pkg::ST_OK) begin
                  if (idx > 4096) e.status = bde_pkg::ST_SIZE_LIMIT;
                  else begin
                     head = 0;
                     count = int'(idx);
                     for (int i = 0; i < count; i++) begin
                        vals[i] = 0;
                        unks[i] = 0;
                     end
                  end
               end
            end
         end
         bde_pkg::REQ_DELETE: begin
            count = 0;
            head = 0;
         end
         bde_pkg::REQ_SIZE: e.value = 64'(count);
         bde_pkg::REQ_READ, bde_pkg::REQ_WRITE: begin
            e.status = idx_check(r, 1, idx);
            if (e.status == bde_pkg::ST_OK) begin
               if (idx >= 64'(count)) e.status = bde_pkg::ST_RANGE;
               else begin
                  s = slot(int'(idx));
                  if (r.kind == bde_pkg::REQ_READ) begin
                     e.value = vals[s];
                     e.unknown = unks[s];
                  end else if (!type_ok(r)) e.status = bde_pkg::ST_MISMATCH;
                  else begin
                     vals[s] = dv;
                     unks[s] = du;
                  end
               end
            end
         end
         bde_pkg::REQ_PUSH_FRONT, bde_pkg::REQ_PUSH_BACK: begin
            if (!is_queue) e.status = bde_pkg::ST_NOT_QUEUE;
            else if (!type_ok(r)) e.status = bde_pkg::ST_MISMATCH;
            else if (r.kind == bde_pkg::REQ_PUSH_FRONT || count < 4096) begin
               if (r.kind == bde_pkg::REQ_PUSH_FRONT) begin
                  head = (head == 0) ? 4095 : head - 1;
                  s = head;
               end else s = slot(count);
               vals[s] = dv;
               unks[s] = du;
               count++;
               if (count > lim) count--;
            end
         end
         bde_pkg::REQ_POP_FRONT, bde_pkg::REQ_POP_BACK: begin
            if (!is_queue) e.status = bde_pkg::ST_NOT_QUEUE;
            else if (count == 0) e.status = bde_pkg::ST_EMPTY;
            else begin
               if (r.kind == bde_pkg::REQ_POP_FRONT) begin
                  s = head;
                  head = slot(1);
               end else s = slot(count - 1);
               e.value = vals[s];
               e.unknown = unks[s];
               count--;
            end
         end
         default: ;
      endcase
      awaited = {awaited, e};
   endfunction

   function void check(deque_rsp_type a);
      deque_rsp_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected response value=%h unknown=%h status=%0d",
                  $time, a.value, a.unknown, a.status);
         errors++;
         return;
      end
      e = awaited.pop_front();
      if (a.value !== e.value) begin
         $display("%0t: value expected %h actual %h", $time, e.value, a.value);
         errors++;
      end
      if (a.unknown !== e.unknown) begin
         $display("%0t: unknown expected %h actual %h", $time, e.unknown, a.unknown);
         errors++;
      end
      if (a.status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
         errors++;
      end
   endfunction
endclass

module tb_bounded_deque_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] REQ_UNUSED = 4'd15;
   localparam int STALL_LIMIT = 30000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [3:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;
   logic        start = 0;
   logic        busy;
   logic [3:0]  req_type = '0;
   logic [63:0] req_index_value = '0;
   logic        req_index_unknown = 0;
   logic [6:0]  req_index_width = '0;
   logic        req_index_signed = 0;
   logic [63:0] req_data_value = '0;
   logic [63:0] req_data_unknown_bits = '0;
   logic [6:0]  req_data_width = 7'd1;
   logic        rsp_valid;
   logic [63:0] rsp_result_value;
   logic [63:0] rsp_result_unknown_bits;
   logic [3:0]  rsp_status;

   deque_scoreboard model = new();
   int idle_pct = 38;
   int stall_cycles = 0;

   bounded_deque_engine_top u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .start(start), .busy(busy), .req_type(req_type),
      .req_index_value(req_index_value), .req_index_unknown(req_index_unknown),
      .req_index_width(req_index_width), .req_index_signed(req_index_signed),
      .req_data_value(req_data_value), .req_data_unknown_bits(req_data_unknown_bits),
      .req_data_width(req_data_width), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value),
      .rsp_result_unknown_bits(rsp_result_unknown_bits), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      deque_rsp_type a;
      if (!reset && rsp_valid) begin
         a.value = rsp_result_value;
         a.unknown = rsp_result_unknown_bits;
         a.status = rsp_status;
         model.check(a);
      end
      if (reset || rsp_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] idx, logic [12:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 0;
      model.set_reg(idx, data);
   endtask

   task automatic send(deque_req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_type <= r.kind;
      req_index_value <= r.idx_v;
      req_index_unknown <= r.idx_u;
      req_index_width <= r.idx_w;
      req_index_signed <= r.idx_s;
      req_data_value <= r.dv;
      req_data_unknown_bits <= r.du;
      req_data_width <= r.dw;
      @(posedge clock);
      while (busy) @(posedge clock);
      model.note(r);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (model.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic deque_req_type mk(logic [3:0] kind, logic [63:0] iv, logic [6:0] iw,
                                        logic [63:0] dv, logic [63:0] du, logic [6:0] dw);
      deque_req_type r;
      r.kind = kind;
      r.idx_v = iv;
      r.idx_u = 0;
      r.idx_w = iw;
      r.idx_s = 0;
      r.dv = dv;
      r.du = du;
      r.dw = dw;
      return r;
   endfunction

   function automatic deque_req_type random_req();
      deque_req_type r;
      int roll;
      roll = $urandom_range(99);
      if (model.is_queue) begin
         if (roll < 30) r.kind = bde_pkg::REQ_PUSH_BACK;
         else if (roll < 50) r.kind = bde_pkg::REQ_PUSH_FRONT;
         else if (roll < 65) r.kind = bde_pkg::REQ_POP_FRONT;
         else if (roll < 78) r.kind = bde_pkg::REQ_POP_BACK;
         else if (roll < 84) r.kind = bde_pkg::REQ_READ;
         else if (roll < 90) r.kind = bde_pkg::REQ_WRITE;
         else if (roll < 93) r.kind = bde_pkg::REQ_SIZE;
         else if (roll < 95) r.kind = bde_pkg::REQ_DELETE;
         else if (roll < 97) r.kind = bde_pkg::REQ_RESIZE;
         else r.kind = 4'($urandom_range(9, 15));
      end else begin
         if (model.count == 0 && roll < 50) r.kind = bde_pkg::REQ_RESIZE;
         else if (roll < 35) r.kind = bde_pkg::REQ_READ;
         else if (roll < 65) r.kind = bde_pkg::REQ_WRITE;
         else if (roll < 72) r.kind = bde_pkg::REQ_SIZE;
         else if (roll < 80) r.kind = bde_pkg::REQ_RESIZE;
         else if (roll < 83) r.kind = bde_pkg::REQ_DELETE;
         else if (roll < 92) r.kind = 4'($urandom_range(5, 8));
         else r.kind = 4'($urandom_range(9, 15));
      end
      r.idx_u = ($urandom_range(99) < 3);
      r.idx_s = 1'($urandom_range(1));
      if (r.kind == bde_pkg::REQ_RESIZE && $urandom_range(99) < 90) begin
         roll = $urandom_range(99);
         r.idx_v = (roll < 97) ? 64'($urandom_range(0, 24)) : (roll < 99) ? 64'd4096 : 64'd4097;
         r.idx_w = 7'($urandom_range(13, 64));
      end else if (model.count > 0 && $urandom_range(99) < 85) begin
         r.idx_v = 64'($urandom_range(0, model.count - 1));
         r.idx_w = 7'($urandom_range(13, 64));
      end else begin
         r.idx_v = {$urandom, $urandom};
         r.idx_w = 7'($urandom_range(0, 127));
      end
      r.dv = {$urandom, $urandom};
      if (model.no_unknown && $urandom_range(99) < 85) r.du = 0;
      else r.du = {$urandom, $urandom} & {$urandom, $urandom};
      r.dw = ($urandom_range(99) < 90) ? 7'(model.elem_w) : 7'($urandom_range(0, 127));
      return r;
   endfunction

   task automatic phase(bit q, int bnd, int ew, bit nu, int n);
      csr_write(bde_pkg::CSR_IS_QUEUE, 13'(q));
      csr_write(bde_pkg::CSR_QUEUE_BOUND, 13'(bnd));
      csr_write(bde_pkg::CSR_ELEMENT_WIDTH, 13'(ew));
      csr_write(bde_pkg::CSR_NO_UNKNOWN, 13'(nu));
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) drain();
         idle_pct = (i >= n / 4 && i < n / 4 + 40) ? 0 : 38;
         send(random_req());
      end
      drain();
   endtask

   initial begin
      deque_req_type r;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // queue mode at reset settings
      send(mk(bde_pkg::REQ_POP_FRONT, 0, 32, 0, 0, 32));
      send(mk(bde_pkg::REQ_POP_BACK, 0, 32, 0, 0, 32));
      send(mk(bde_pkg::REQ_RESIZE, 4, 32, 0, 0, 32));
      send(mk(bde_pkg::REQ_PUSH_BACK, 0, 32, 64'h1234, 0, 31));
      send(mk(bde_pkg::REQ_PUSH_FRONT, 0, 32, '1, '1, 32));
      send(mk(bde_pkg::REQ_PUSH_BACK, 0, 32, 64'h0, 64'hF0F0, 32));
      send(mk(bde_pkg::REQ_PUSH_BACK, 0, 32, 64'hDEAD_BEEF_CAFE_F00D, 0, 32));
      send(mk(bde_pkg::REQ_SIZE, 0, 0, 0, 0, 32));
      send(mk(bde_pkg::REQ_READ, 0, 64, 0, 0, 32));
      send(mk(bde_pkg::REQ_READ, 0, 0, 0, 0, 32));
      send(mk(bde_pkg::REQ_READ, 1, 65, 0, 0, 32));
      r = mk(bde_pkg::REQ_READ, 1, 8, 0, 0, 32);
      r.idx_u = 1;
      send(r);
      r = mk(bde_pkg::REQ_READ, 64'h8000_0000, 32, 0, 0, 32);
      r.idx_s = 1;
      send(r);
      r = mk(bde_pkg::REQ_READ, 64'hFFFF_FFFF_0000_0001, 32, 0, 0, 32);
      r.idx_s = 1;
      send(r);
      send(mk(bde_pkg::REQ_READ, '1, 64, 0, 0, 32));
      send(mk(bde_pkg::REQ_WRITE, 1, 16, 64'h55, 64'h3, 32));
      send(mk(bde_pkg::REQ_READ, 1, 16, 0, 0, 32));
      send(mk(bde_pkg::REQ_POP_FRONT, 0, 0, 0, 0, 0));
      send(mk(bde_pkg::REQ_POP_BACK, 0, 0, 0, 0, 0));
      send(mk(REQ_UNUSED, '1, 7'h7F, '1, '1, 7'h7F));
      send(mk(bde_pkg::REQ_DELETE, 0, 0, 0, 0, 0));
      send(mk(bde_pkg::REQ_SIZE, 0, 0, 0, 0, 0));
      drain();

      // array mode: size limits, then leave the store full for the queue phase
      csr_write(bde_pkg::CSR_IS_QUEUE, 13'd0);
      send(mk(bde_pkg::REQ_RESIZE, 4097, 64, 0, 0, 32));
      send(mk(bde_pkg::REQ_PUSH_BACK, 0, 0, 0, 0, 32));
      send(mk(bde_pkg::REQ_RESIZE, 4096, 64, 0, 0, 32));
      send(mk(bde_pkg::REQ_READ, 4095, 13, 0, 0, 32));
      drain();
      csr_write(bde_pkg::CSR_IS_QUEUE, 13'd1);
      send(mk(bde_pkg::REQ_PUSH_BACK, 0, 0, 64'h77, 0, 32));
      send(mk(bde_pkg::REQ_PUSH_FRONT, 0, 0, 64'h99, 0, 32));
      send(mk(bde_pkg::REQ_POP_BACK, 0, 0, 0, 0, 0));
      send(mk(bde_pkg::REQ_POP_FRONT, 0, 0, 0, 0, 0));
      send(mk(bde_pkg::REQ_DELETE, 0, 0, 0, 0, 0));
      drain();

      phase(1, 0, 32, 0, 220);
      phase(1, 3, 8, 1, 180);
      phase(0, 0, 64, 0, 220);
      phase(1, 4096, 1, 0, 180);
      phase(0, 0, 1, 1, 160);
      phase(1, 8191, 64, 1, 180);
      phase(1, 1, 17, 0, 160);

      if (model.errors == 0 && model.awaited.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

`default_nettype wire
